// ===== rtl/kdmma_pkg.sv =====
`timescale 1ns / 1ps

package kdmma_pkg;

  localparam int unsigned KEY_W = 8;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned MIN_OUT_W = 15;

  // weight is Q1.12, 4096 = 1.0
  localparam int unsigned W_W = 13;
  localparam logic [W_W-1:0] W_ONE = 13'd4096;
  localparam int unsigned FRAC_BITS = 12;

  // x = 4*elapsed + 2; w = x / 5, saturated once x reaches 5 * 4097
  localparam int unsigned WX_W = 18;
  localparam logic [WX_W-1:0] WX_SAT = 18'd20485;
  localparam int unsigned WQ_W = 15;
  localparam logic [16:0] RECIP5 = 17'd52429;
  localparam int unsigned RECIP5_SHIFT = 18;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BM_AVG = 2'd0,
    BM_MIN = 2'd1,
    BM_MAX = 2'd2
  } blend_mode_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] avg;
    logic signed [VAL_W-1:0] mn;
    logic signed [VAL_W-1:0] mx;
  } entry_t;

endpackage

// ===== rtl/kdmma_blend.sv =====
`timescale 1ns / 1ps

module kdmma_blend import kdmma_pkg::*; (
  input  blend_mode_t             mode,
  input  logic signed [VAL_W-1:0] old_val,
  input  logic signed [VAL_W-1:0] new_val,
  input  logic [W_W-1:0]          weight,
  output logic signed [VAL_W-1:0] result
);

  logic signed [VAL_W:0]       diff;
  logic signed [VAL_W+W_W:0]   prod;
  logic signed [VAL_W+W_W:0]   rounded;
  logic signed [VAL_W+W_W:0]   shifted;
  logic signed [VAL_W:0]       mixed;
  logic signed [VAL_W-1:0]     blended;

  // old + round_floor((new - old) * w / 4096)
  always_comb begin
    diff    = {new_val[VAL_W-1], new_val} - {old_val[VAL_W-1], old_val};
    prod    = diff * $signed({1'b0, weight});
    rounded = prod + (VAL_W+W_W+1)'(1 << (FRAC_BITS - 1));
    shifted = rounded >>> FRAC_BITS;
    mixed   = {old_val[VAL_W-1], old_val} + shifted[VAL_W:0];
    blended = mixed[VAL_W-1:0];
  end

  always_comb begin
    case (mode)
      BM_AVG: result = blended;
      BM_MIN: begin
        result = (new_val < old_val) ? new_val : blended;
        if (result < 0) begin
          result = '0;
        end
      end
      BM_MAX: result = (new_val > old_val) ? new_val : blended;
      default: result = blended;
    endcase
  end

endmodule

// ===== rtl/keyed_decaying_min_max_average.sv =====
`timescale 1ns / 1ps
// Each input is searched one table entry compared per cycle through a registered read;
// on a hit the average, minimum and maximum are then updated in turn on the shared blend unit.
// The block accepts no new input while an item is being searched and updated, nor while
// its result waits for the output to be free.
// Reset (rst_n low, synchronous): table empties, no result pending; table contents
// are not cleared.
module keyed_decaying_min_max_average import kdmma_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] region_key, [23:8] percent_value, [39:24] frame_elapsed
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] average_out, [30:16] minimum_out, [46:31] maximum_out, [47] zero
  output logic [47:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_UPDATE = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] rdaddr_r, rdaddr_nxt;
  logic [IDX_W-1:0] q_idx_r;
  logic             q_vld_r, q_vld_nxt;
  logic [IDX_W-1:0] widx_r, widx_nxt;
  logic [1:0]       step_r, step_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [47:0]      out_tdata_r, out_tdata_nxt;
  status_t          out_status_r, out_status_nxt;

  logic [KEY_W-1:0]        key_r, key_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [W_W-1:0]          w_r, w_nxt;
  logic signed [VAL_W-1:0] avg_r, avg_nxt;
  logic signed [VAL_W-1:0] mn_r, mn_nxt;
  logic signed [VAL_W-1:0] mx_r, mx_nxt;
  status_t                 status_r, status_nxt;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q_r;
  entry_t wr_entry;
  logic   mem_we;

  logic [KEY_W-1:0]        in_key;
  logic signed [VAL_W-1:0] in_val;
  logic [ELAPSED_W-1:0]    in_elapsed;
  logic [WX_W-1:0]         wx;
  logic [WQ_W+16:0]        wq_prod;
  logic [W_W-1:0]          in_w;

  blend_mode_t             bmode;
  logic signed [VAL_W-1:0] bold;
  logic signed [VAL_W-1:0] bres;
  logic                    out_free;
  logic                    in_fire;

  assign in_key     = in_tdata[7:0];
  assign in_val     = $signed(in_tdata[23:8]);
  assign in_elapsed = in_tdata[39:24];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_status_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // w = round(0.8 * elapsed) in Q1.12, saturated at 1.0
  always_comb begin
    wx      = {in_elapsed, 2'b00} + WX_W'(2);
    wq_prod = wx[WQ_W-1:0] * RECIP5;
    if (wx >= WX_SAT) begin
      in_w = W_ONE;
    end else begin
      in_w = wq_prod[RECIP5_SHIFT+W_W-1:RECIP5_SHIFT];
    end
  end

  always_comb begin
    case (step_r)
      2'd0: begin
        bmode = BM_AVG;
        bold  = avg_r;
      end
      2'd1: begin
        bmode = BM_MIN;
        bold  = mn_r;
      end
      2'd2: begin
        bmode = BM_MAX;
        bold  = mx_r;
      end
      default: begin
        bmode = BM_AVG;
        bold  = avg_r;
      end
    endcase
  end

  kdmma_blend u_blend (
    .mode    (bmode),
    .old_val (bold),
    .new_val (val_r),
    .weight  (w_r),
    .result  (bres)
  );

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    rdaddr_nxt     = rdaddr_r;
    q_vld_nxt      = 1'b0;
    widx_nxt       = widx_r;
    step_nxt       = step_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_status_nxt = out_status_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    w_nxt          = w_r;
    avg_nxt        = avg_r;
    mn_nxt         = mn_r;
    mx_nxt         = mx_r;
    status_nxt     = status_r;
    mem_we         = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt = in_key;
          val_nxt = in_val;
          w_nxt   = in_w;
          if (fill_r == '0) begin
            widx_nxt   = '0;
            avg_nxt    = in_val;
            mn_nxt     = (in_val < 0) ? '0 : in_val;
            mx_nxt     = in_val;
            status_nxt = ST_NEW;
            state_nxt  = S_DONE;
          end else begin
            rdaddr_nxt = '0;
            state_nxt  = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        rdaddr_nxt = rdaddr_r + CNT_W'(1);
        q_vld_nxt  = (rdaddr_r < fill_r);
        if (q_vld_r && (rd_q_r.key == key_r)) begin
          q_vld_nxt  = 1'b0;
          widx_nxt   = q_idx_r;
          avg_nxt    = rd_q_r.avg;
          mn_nxt     = rd_q_r.mn;
          mx_nxt     = rd_q_r.mx;
          status_nxt = ST_HIT;
          step_nxt   = 2'd0;
          state_nxt  = S_UPDATE;
        end else if (q_vld_r && (CNT_W'(q_idx_r) == fill_r - CNT_W'(1))) begin
          q_vld_nxt = 1'b0;
          state_nxt = S_DONE;
          if (fill_r == CNT_W'(TABLE_ENTRIES)) begin
            avg_nxt    = '0;
            mn_nxt     = '0;
            mx_nxt     = '0;
            status_nxt = ST_FULL;
          end else begin
            widx_nxt   = fill_r[IDX_W-1:0];
            avg_nxt    = val_r;
            mn_nxt     = (val_r < 0) ? '0 : val_r;
            mx_nxt     = val_r;
            status_nxt = ST_NEW;
          end
        end
      end
      S_UPDATE: begin
        case (bmode)
          BM_AVG: avg_nxt = bres;
          BM_MIN: mn_nxt  = bres;
          BM_MAX: mx_nxt  = bres;
          default: avg_nxt = bres;
        endcase
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, mx_r, mn_r[MIN_OUT_W-1:0], avg_r};
          out_status_nxt = status_r;
          mem_we         = (status_r != ST_FULL);
          if (status_r == ST_NEW) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    wr_entry.key = key_r;
    wr_entry.avg = avg_r;
    wr_entry.mn  = mn_r;
    wr_entry.mx  = mx_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[widx_r] <= wr_entry;
    end
    rd_q_r  <= mem[rdaddr_r[IDX_W-1:0]];
    q_idx_r <= rdaddr_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      q_vld_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      q_vld_r      <= q_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdaddr_r     <= rdaddr_nxt;
    widx_r       <= widx_nxt;
    step_r       <= step_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_status_r <= out_status_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    w_r          <= w_nxt;
    avg_r        <= avg_nxt;
    mn_r         <= mn_nxt;
    mx_r         <= mx_nxt;
    status_r     <= status_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted twice in a row");

  a_new_grows_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_free && (status_r == ST_NEW)
    |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && (out_status_r == ST_FULL) |-> out_tdata_r == '0)
    else $error("full result carries data");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_tuser != 2'd3)
    else $error("undefined status code");

endmodule

// ===== tb/keyed_decaying_min_max_average_tb.sv =====
`timescale 1ns / 1ps

module keyed_decaying_min_max_average_tb;
  import kdmma_pkg::*;

  localparam int unsigned ENTRIES = 64;
  localparam int          WEIGHT_ONE = 4096;
  localparam int          STALL_LIMIT = 2000;
  localparam int          SETTLE_CYCLES = 100;
  localparam int          RANDOM_ITEMS = 900;

  typedef struct {
    logic signed [15:0] avg;
    logic [14:0]        mn;
    logic signed [15:0] mx;
    status_t            st;
  } region_tally_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  keyed_decaying_min_max_average #(
    .TABLE_ENTRIES(ENTRIES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // predictor state
  int unsigned        region_fill;
  logic [7:0]         region_key [ENTRIES];
  logic signed [15:0] region_avg [ENTRIES];
  logic signed [15:0] region_min [ENTRIES];
  logic signed [15:0] region_max [ENTRIES];

  region_tally_t pending_tallies[$];
  int            err_count;
  int            results_seen;
  int            status_seen[3];
  int            idle_cycles;
  bit            steady;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int find_region(input logic [7:0] key);
    for (int i = 0; i < region_fill; i++) begin
      if (region_key[i] == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  // rounded (ties up) Q1.12 blend of prev toward val
  function automatic logic signed [15:0] blend_q12(input logic signed [15:0] prev,
                                                   input logic signed [15:0] val,
                                                   input int w);
    longint acc;
    acc = longint'(prev) * (WEIGHT_ONE - w) + longint'(val) * w + WEIGHT_ONE / 2;
    acc = acc >>> 12;
    return acc[15:0];
  endfunction

  function automatic region_tally_t track_region(input logic [7:0] key,
                                                 input logic signed [15:0] val,
                                                 input logic [15:0] elapsed);
    region_tally_t t;
    int w;
    int slot;
    w = (int'(elapsed) * 4 + 2) / 5;
    if (w > WEIGHT_ONE) begin
      w = WEIGHT_ONE;
    end
    slot = find_region(key);
    t.avg = '0;
    t.mn = '0;
    t.mx = '0;
    t.st = ST_FULL;
    if (slot >= 0) begin
      region_avg[slot] = blend_q12(region_avg[slot], val, w);
      if (val < region_min[slot]) begin
        region_min[slot] = val;
      end else begin
        region_min[slot] = blend_q12(region_min[slot], val, w);
      end
      if (region_min[slot] < 0) begin
        region_min[slot] = '0;
      end
      if (val > region_max[slot]) begin
        region_max[slot] = val;
      end else begin
        region_max[slot] = blend_q12(region_max[slot], val, w);
      end
      t.st = ST_HIT;
    end else if (region_fill < ENTRIES) begin
      slot = region_fill;
      region_key[slot] = key;
      region_avg[slot] = val;
      region_min[slot] = (val < 0) ? 16'sd0 : val;
      region_max[slot] = val;
      region_fill++;
      t.st = ST_NEW;
    end
    if (slot >= 0) begin
      t.avg = region_avg[slot];
      t.mn = region_min[slot][14:0];
      t.mx = region_max[slot];
    end
    return t;
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(signed'($urandom_range(8)) - 4);
      3, 4: return 16'($urandom_range(25600));
      5: return -16'sd1 * 16'($urandom_range(2560));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(19))
      0, 1, 2: return 16'd0;
      3: return 16'hffff;
      4: return 16'(5119 + $urandom_range(3));
      5, 6, 7, 8, 9, 10, 11, 12: return 16'($urandom_range(5200));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < 20) begin
      $display("%0t mismatch on result %0d, %s: got 'h%0h expected 'h%0h",
               $realtime, results_seen, what, got, want);
    end
    err_count++;
  endtask

  task automatic send_item(input logic [7:0] key, input logic signed [15:0] val,
                           input logic [15:0] elapsed);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {elapsed, val, key};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    pending_tallies.push_back(track_region(key, val, elapsed));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_tallies.size() > 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_first_inserts();
    send_item(8'h00, 16'sh8000, 16'd0);
    send_item(8'hff, 16'sh7fff, 16'hffff);
    send_item(8'h5a, 16'sh0000, 16'd5120);
    send_item(8'ha5, -16'sd1, 16'd1);
  endtask

  task automatic test_hit_blending();
    send_item(8'h00, 16'sh7fff, 16'd0);
    send_item(8'h00, 16'sh8000, 16'hffff);
    send_item(8'h00, 16'sd300, 16'd2560);
    send_item(8'hff, 16'sd100, 16'd1);
    send_item(8'hff, -16'sd1, 16'd5121);
    send_item(8'hff, 16'sd7, 16'd5119);
    send_item(8'h5a, 16'sh7fff, 16'd2560);
    send_item(8'h5a, -16'sd3, 16'd3);
    send_item(8'h5a, -16'sd3, 16'd0);
    send_item(8'ha5, 16'sh8000, 16'd4000);
    send_item(8'ha5, 16'sh7fff, 16'h8000);
    send_item(8'ha5, 16'sd1, 16'd6);
  endtask

  task automatic test_fill_to_capacity();
    logic [7:0] key;
    while (region_fill < ENTRIES) begin
      if ($urandom_range(1) == 0) begin
        key = region_key[$urandom_range(region_fill - 1)];
      end else begin
        do key = 8'($urandom); while (find_region(key) >= 0);
      end
      send_item(key, pick_value(), pick_elapsed());
    end
    for (int i = 0; i < 3; i++) begin
      do key = 8'($urandom); while (find_region(key) >= 0);
      send_item(key, pick_value(), pick_elapsed());
    end
    send_item(region_key[0], pick_value(), pick_elapsed());
    send_item(region_key[ENTRIES-1], pick_value(), pick_elapsed());
  endtask

  task automatic test_random_traffic();
    logic [7:0] key;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 400 && n < 600);
      if ($urandom_range(4) != 0) begin
        key = region_key[$urandom_range(ENTRIES - 1)];
      end else begin
        key = 8'($urandom);
      end
      send_item(key, pick_value(), pick_elapsed());
    end
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin : check_results
    region_tally_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_tallies.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata, 0);
      end else begin
        want = pending_tallies.pop_front();
        status_seen[want.st]++;
        if (out_tdata[15:0] !== want.avg) begin
          report_mismatch("average_out", out_tdata[15:0], want.avg);
        end
        if (out_tdata[30:16] !== want.mn) begin
          report_mismatch("minimum_out", out_tdata[30:16], want.mn);
        end
        if (out_tdata[46:31] !== want.mx) begin
          report_mismatch("maximum_out", out_tdata[46:31], want.mx);
        end
        if (out_tdata[47] !== 1'b0) begin
          report_mismatch("pad bit", out_tdata[47], 0);
        end
        if (out_tuser !== want.st) begin
          report_mismatch("status", out_tuser, want.st);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    steady = 1'b0;
    region_fill = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_first_inserts();
    test_hit_blending();
    test_fill_to_capacity();
    test_random_traffic();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d results: %0d updates, %0d inserts, %0d table-full misses",
             results_seen, status_seen[ST_HIT], status_seen[ST_NEW], status_seen[ST_FULL]);
    $display("%0d mismatches, %0d expected results left over", err_count,
             pending_tallies.size());
    if (err_count == 0 && pending_tallies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
